// File: rtl/rv32_subset_execute_unit_defines.svh
// ---------------------------------------------------------------------------
// rv32_subset_execute_unit_defines.svh
// Assertion macros used by the execute unit's property checker.
// ---------------------------------------------------------------------------
`ifndef RV32_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define RV32_SUBSET_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RV32EU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv32eu assertion failed");

// next-cycle implication, disabled while in reset
`define RV32EU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv32eu assertion failed");

`endif

// File: rtl/rv32eu_pkg.sv
// ---------------------------------------------------------------------------
// rv32eu_pkg
// Shared constants, opcodes and interface structs of the execute unit.
// ---------------------------------------------------------------------------
package rv32eu_pkg;

  localparam int unsigned MEM_BYTES  = 4096;
  localparam logic [31:0] START_PC   = 32'h0000_0000;
  localparam int unsigned REG_COUNT  = 32;
  localparam int unsigned RF_IDX_W   = $clog2(REG_COUNT);

  // data memory is split into four byte banks, one per address lane
  localparam int unsigned DMEM_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int unsigned DMEM_ROW_W = (DMEM_DEPTH > 1) ? $clog2(DMEM_DEPTH) : 1;
  localparam int unsigned DMEM_AW    = DMEM_ROW_W + 2;
  localparam logic [31:0] MAX_ADDR   = 32'(MEM_BYTES - 4);

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 136;

  typedef enum logic [3:0] {
    CMD_ADDI = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_AND  = 4'd3,
    CMD_OR   = 4'd4,
    CMD_XOR  = 4'd5,
    CMD_ANDI = 4'd6,
    CMD_ORI  = 4'd7,
    CMD_LW   = 4'd8,
    CMD_SW   = 4'd9,
    CMD_BEQ  = 4'd10,
    CMD_BNE  = 4'd11
  } cmd_t;

  typedef struct packed {
    logic                re;
    logic [RF_IDX_W-1:0] raddr1;
    logic [RF_IDX_W-1:0] raddr2;
  } rf_rd_t;

  typedef struct packed {
    logic                we;
    logic [RF_IDX_W-1:0] idx;
    logic [31:0]         data;
  } rf_wr_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [DMEM_AW-1:0] addr;
    logic [31:0]        wdata;
  } dmem_req_t;

endpackage

// File: rtl/rv32eu_regfile.sv
// ---------------------------------------------------------------------------
// rv32eu_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ---------------------------------------------------------------------------
module rv32eu_regfile
  import rv32eu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rf_rd_t      rd_req,
  input  rf_wr_t      wr_req,
  output logic [31:0] rdata1,
  output logic [31:0] rdata2
);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]          q1_r;
  logic [31:0]          q2_r;
  logic                 v1_r;
  logic                 v2_r;

  // valid bits stand in for the reset clear: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.we) begin
      valid_r[wr_req.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      mem[wr_req.idx] <= wr_req.data;
    end
    if (rd_req.re) begin
      q1_r <= mem[rd_req.raddr1];
      q2_r <= mem[rd_req.raddr2];
      v1_r <= valid_r[rd_req.raddr1];
      v2_r <= valid_r[rd_req.raddr2];
    end
  end

  assign rdata1 = v1_r ? q1_r : 32'd0;
  assign rdata2 = v2_r ? q2_r : 32'd0;

endmodule

// File: rtl/rv32eu_dmem.sv
// ---------------------------------------------------------------------------
// rv32eu_dmem
// Byte-addressed data memory in four byte banks; unaligned little-endian
// word access, registered read, clearing sweep after reset.
// ---------------------------------------------------------------------------
module rv32eu_dmem
  import rv32eu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dmem_req_t   req,
  output logic [31:0] rdata,
  output logic        busy
);

  logic                  clearing_r;
  logic [DMEM_ROW_W-1:0] clr_row_r;
  logic [1:0]            lane_r;
  logic [31:0]           wrot;
  logic [31:0]           bank_q;
  logic [4:0]            lane_sh;
  logic [4:0]            lane_sh_q;

  assign busy      = clearing_r;
  assign lane_sh   = {req.addr[1:0], 3'b000};
  assign lane_sh_q = {lane_r, 3'b000};
  assign wrot      = (req.wdata << lane_sh) | (req.wdata >> (6'd32 - {1'b0, lane_sh}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clearing_r) begin
      if (clr_row_r == DMEM_ROW_W'(DMEM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_row_r <= clr_row_r + DMEM_ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!clearing_r && req.re) begin
      lane_r <= req.addr[1:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]            mem [DMEM_DEPTH];
    logic [1:0]            off;
    logic [DMEM_AW-1:0]    baddr;
    logic [DMEM_ROW_W-1:0] row;
    logic                  wen;
    logic [DMEM_ROW_W-1:0] wrow;
    logic [7:0]            wbyte;
    logic [7:0]            q_r;

    assign off   = 2'(k) - req.addr[1:0];
    assign baddr = req.addr + DMEM_AW'(off);
    assign row   = baddr[DMEM_AW-1:2];
    assign wen   = clearing_r || req.we;
    assign wrow  = clearing_r ? clr_row_r : row;
    assign wbyte = clearing_r ? 8'h00 : wrot[8*k +: 8];

    always_ff @(posedge clk) begin
      if (wen) begin
        mem[wrow] <= wbyte;
      end
      if (!clearing_r && req.re) begin
        q_r <= mem[row];
      end
    end

    assign bank_q[8*k +: 8] = q_r;
  end

  assign rdata = (bank_q >> lane_sh_q) | (bank_q << (6'd32 - {1'b0, lane_sh_q}));

endmodule

// File: rtl/rv32_subset_execute_unit.sv
// ---------------------------------------------------------------------------
// rv32_subset_execute_unit
// Executes decoded RV32I-subset instructions against a register file,
// a byte data memory and a program counter.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded instruction per word (cmd, registers, immediate,
//           branch target). out_* : one result word per instruction, in order.
//   Stages: register read (at accept), execute, memory (loads only), output
//   register. Throughput is one instruction per cycle for ALU ops, stores
//   and branches while out_tready is high; a lw holds the input while it is
//   in execute, since its register write comes from the registered data
//   memory read port. Results are forwarded to the next instruction's
//   register read.
//   Reset sets the PC to START_PC and clears the register file at once
//   (valid bits); the data memory is cleared by a sweep of its MEM_BYTES/4
//   rows (1024 by default), during which in_tready stays low.
//   When out_tready is low the result waits in the output register; one
//   more instruction may be taken into execute before the input stalls.
// ---------------------------------------------------------------------------
module rv32_subset_execute_unit
  import rv32eu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cmd[3:0], dest_reg[8:4], src1_reg[13:9], src2_reg[18:14],
  // immediate[50:19], branch_target[82:51], zero pad[87:83]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_pc[31:0], reg_written[32], written_index[37:33],
  // written_value[69:38], bounds_error[70], store_done[71],
  // store_address[103:72], store_value[135:104]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  dmem_req_t   dm_req;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] dm_rdata;
  logic        dm_busy;

  // execute stage
  logic                e_valid_r;
  cmd_t                e_cmd_r;
  logic [RF_IDX_W-1:0] e_rd_r;
  logic [RF_IDX_W-1:0] e_src1_r;
  logic [RF_IDX_W-1:0] e_src2_r;
  logic [31:0]         e_imm_r;
  logic [31:0]         e_target_r;

  // forward of the register write made at the accept edge
  logic                fwd_v_r;
  logic [RF_IDX_W-1:0] fwd_idx_r;
  logic [31:0]         fwd_data_r;

  // memory stage
  logic                m_valid_r;
  logic [RF_IDX_W-1:0] m_rd_r;
  logic                m_err_r;
  logic [31:0]         m_pc_r;

  logic [31:0] pc_r;
  logic [31:0] pc_nxt;
  logic [31:0] ls_addr_r;
  logic [31:0] ls_addr_nxt;
  logic [31:0] ls_val_r;
  logic [31:0] ls_val_nxt;

  logic                out_valid_r;
  logic [31:0]         out_pc_r;
  logic                out_rw_r;
  logic [RF_IDX_W-1:0] out_idx_r;
  logic [31:0]         out_val_r;
  logic                out_err_r;
  logic                out_st_r;
  logic [31:0]         out_sa_r;
  logic [31:0]         out_sv_r;

  logic        op_a;
  logic        op_b;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] e_addr;
  logic        e_inb;
  logic [31:0] alu;
  logic        e_alu;
  logic        e_rw;
  logic        e_lw;
  logic        e_sw;
  logic        e_taken;
  logic [31:0] e_next_pc;
  logic        m_rw;
  logic        out_free;
  logic        e_adv;
  logic        m_adv;
  logic        e_out;
  logic        accept;

  rv32eu_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rf_rd),
    .wr_req (rf_wr),
    .rdata1 (rf_a),
    .rdata2 (rf_b)
  );

  rv32eu_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dm_req),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  // operands and execute
  assign op_a   = fwd_v_r && (fwd_idx_r == e_src1_r);
  assign op_b   = fwd_v_r && (fwd_idx_r == e_src2_r);
  assign a      = op_a ? fwd_data_r : rf_a;
  assign b      = op_b ? fwd_data_r : rf_b;
  assign e_addr = a + e_imm_r;
  assign e_inb  = (e_addr <= MAX_ADDR);
  assign e_lw   = (e_cmd_r == CMD_LW);
  assign e_sw   = (e_cmd_r == CMD_SW);

  always_comb begin
    alu     = 32'd0;
    e_alu   = 1'b1;
    e_taken = 1'b0;
    case (e_cmd_r)
      CMD_ADDI: alu = e_addr;
      CMD_ADD:  alu = a + b;
      CMD_SUB:  alu = a - b;
      CMD_AND:  alu = a & b;
      CMD_OR:   alu = a | b;
      CMD_XOR:  alu = a ^ b;
      CMD_ANDI: alu = a & e_imm_r;
      CMD_ORI:  alu = a | e_imm_r;
      CMD_BEQ: begin
        e_alu   = 1'b0;
        e_taken = (a == b);
      end
      CMD_BNE: begin
        e_alu   = 1'b0;
        e_taken = (a != b);
      end
      default: e_alu = 1'b0;
    endcase
  end

  assign e_rw      = e_alu && (e_rd_r != '0);
  assign e_next_pc = e_taken ? e_target_r : pc_r + 32'd4;
  assign m_rw      = !m_err_r && (m_rd_r != '0);

  // flow control
  assign out_free  = !out_valid_r || out_tready;
  assign m_adv     = m_valid_r && out_free;
  assign e_adv     = e_valid_r && !m_valid_r && (e_lw || out_free);
  assign e_out     = e_adv && !e_lw;
  assign in_tready = !dm_busy && (!e_valid_r || e_out) && (!m_valid_r || m_adv);
  assign accept    = in_tvalid && in_tready;

  assign rf_rd.re     = accept;
  assign rf_rd.raddr1 = in_tdata[13:9];
  assign rf_rd.raddr2 = in_tdata[18:14];

  assign rf_wr.we   = (e_out && e_rw) || (m_adv && m_rw);
  assign rf_wr.idx  = m_adv ? m_rd_r : e_rd_r;
  assign rf_wr.data = m_adv ? dm_rdata : alu;

  assign dm_req.we    = e_adv && e_sw && e_inb;
  assign dm_req.re    = e_adv && e_lw && e_inb;
  assign dm_req.addr  = e_addr[DMEM_AW-1:0];
  assign dm_req.wdata = b;

  assign pc_nxt      = e_adv ? e_next_pc : pc_r;
  assign ls_addr_nxt = dm_req.we ? e_addr : ls_addr_r;
  assign ls_val_nxt  = dm_req.we ? b : ls_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_v_r     <= 1'b0;
      pc_r        <= START_PC;
      ls_addr_r   <= 32'hFFFF_FFFF;
      ls_val_r    <= 32'd0;
    end else begin
      pc_r      <= pc_nxt;
      ls_addr_r <= ls_addr_nxt;
      ls_val_r  <= ls_val_nxt;
      if (accept) begin
        e_valid_r <= 1'b1;
        fwd_v_r   <= rf_wr.we;
      end else if (e_adv) begin
        e_valid_r <= 1'b0;
      end
      if (e_adv && e_lw) begin
        m_valid_r <= 1'b1;
      end else if (m_adv) begin
        m_valid_r <= 1'b0;
      end
      if (e_out || m_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_cmd_r    <= cmd_t'(in_tdata[3:0]);
      e_rd_r     <= in_tdata[8:4];
      e_src1_r   <= in_tdata[13:9];
      e_src2_r   <= in_tdata[18:14];
      e_imm_r    <= in_tdata[50:19];
      e_target_r <= in_tdata[82:51];
      fwd_idx_r  <= rf_wr.idx;
      fwd_data_r <= rf_wr.data;
    end
    if (e_adv && e_lw) begin
      m_rd_r  <= e_rd_r;
      m_err_r <= !e_inb;
      m_pc_r  <= e_next_pc;
    end
    if (m_adv) begin
      out_pc_r  <= m_pc_r;
      out_rw_r  <= m_rw;
      out_idx_r <= m_rw ? m_rd_r : '0;
      out_val_r <= m_rw ? dm_rdata : 32'd0;
      out_err_r <= m_err_r;
      out_st_r  <= 1'b0;
      out_sa_r  <= ls_addr_r;
      out_sv_r  <= ls_val_r;
    end else if (e_out) begin
      out_pc_r  <= e_next_pc;
      out_rw_r  <= e_rw;
      out_idx_r <= e_rw ? e_rd_r : '0;
      out_val_r <= e_rw ? alu : 32'd0;
      out_err_r <= e_sw && !e_inb;
      out_st_r  <= e_sw && e_inb;
      out_sa_r  <= ls_addr_nxt;
      out_sv_r  <= ls_val_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_sv_r, out_sa_r, out_st_r, out_err_r, out_val_r,
                       out_idx_r, out_rw_r, out_pc_r};

endmodule

// File: rtl/rv32eu_props.sv
// ---------------------------------------------------------------------------
// rv32eu_props
// Port-level checks on the execute unit's result stream.
// ---------------------------------------------------------------------------
`include "rv32_subset_execute_unit_defines.svh"

module rv32eu_props
  import rv32eu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic rw;
  logic err;
  logic st;

  assign rw  = out_tdata[32];
  assign err = out_tdata[70];
  assign st  = out_tdata[71];

  `RV32EU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RV32EU_ASSERT_IMPLY(a_no_write_zero, clk, rst_n, out_tvalid && !rw, out_tdata[69:33] == '0)
  `RV32EU_ASSERT_IMPLY(a_write_nonzero, clk, rst_n, out_tvalid && rw, out_tdata[37:33] != '0)
  `RV32EU_ASSERT_IMPLY(a_err_excl, clk, rst_n, out_tvalid && err, !st && !rw)
  `RV32EU_ASSERT_IMPLY(a_store_inb, clk, rst_n, out_tvalid && st, out_tdata[103:72] <= MAX_ADDR)

endmodule

bind rv32_subset_execute_unit rv32eu_props u_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: test/rv32_subset_execute_unit_checker.sv
// ---------------------------------------------------------------------------
// rv32_subset_execute_unit_checker
// Watches both streams of the execute unit. Every accepted instruction word
// is run through a local copy of the PC, register file and data memory, and
// the expected result word is queued. Every accepted result word is compared
// with the oldest queued one. Mismatches and unexpected results are counted.
// ---------------------------------------------------------------------------
module rv32_subset_execute_unit_checker
  import rv32eu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatch_count,
  output int                     retire_pending,
  output int                     retired_count
);

  localparam int unsigned MA_W = $clog2(MEM_BYTES);

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] target;
    logic [31:0] imm;
    logic [4:0]  rs2;
    logic [4:0]  rs1;
    logic [4:0]  rd;
    logic [3:0]  cmd;
  } instr_t;

  typedef struct packed {
    logic [31:0] st_val;
    logic [31:0] st_addr;
    logic        store_done;
    logic        bounds_err;
    logic [31:0] wr_val;
    logic [4:0]  wr_idx;
    logic        reg_written;
    logic [31:0] next_pc;
  } retire_t;

  logic [31:0] pc;
  logic [31:0] gpr [REG_COUNT];
  logic [7:0]  dmem [MEM_BYTES];
  logic [31:0] last_st_addr;
  logic [31:0] last_st_val;
  retire_t     retire_q [$];

  function automatic retire_t retire_instr(instr_t ins);
    retire_t     res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] addr;
    logic [MA_W-1:0] ma;
    logic        in_range;
    a        = gpr[ins.rs1];
    b        = gpr[ins.rs2];
    addr     = a + ins.imm;
    ma       = addr[MA_W-1:0];
    in_range = (64'(addr) + 64'd3) < 64'(MEM_BYTES);
    res      = '0;
    pc       = pc + 32'd4;
    case (ins.cmd)
      CMD_ADDI: begin res.wr_val = a + ins.imm; res.reg_written = 1'b1; end
      CMD_ADD:  begin res.wr_val = a + b;       res.reg_written = 1'b1; end
      CMD_SUB:  begin res.wr_val = a - b;       res.reg_written = 1'b1; end
      CMD_AND:  begin res.wr_val = a & b;       res.reg_written = 1'b1; end
      CMD_OR:   begin res.wr_val = a | b;       res.reg_written = 1'b1; end
      CMD_XOR:  begin res.wr_val = a ^ b;       res.reg_written = 1'b1; end
      CMD_ANDI: begin res.wr_val = a & ins.imm; res.reg_written = 1'b1; end
      CMD_ORI:  begin res.wr_val = a | ins.imm; res.reg_written = 1'b1; end
      CMD_LW: begin
        if (in_range) begin
          res.wr_val = {dmem[ma + MA_W'(3)], dmem[ma + MA_W'(2)],
                        dmem[ma + MA_W'(1)], dmem[ma]};
          res.reg_written = 1'b1;
        end else begin
          res.bounds_err = 1'b1;
        end
      end
      CMD_SW: begin
        if (in_range) begin
          dmem[ma]              = b[7:0];
          dmem[ma + MA_W'(1)]   = b[15:8];
          dmem[ma + MA_W'(2)]   = b[23:16];
          dmem[ma + MA_W'(3)]   = b[31:24];
          last_st_addr          = addr;
          last_st_val           = b;
          res.store_done        = 1'b1;
        end else begin
          res.bounds_err = 1'b1;
        end
      end
      CMD_BEQ: if (a == b) pc = ins.target;
      CMD_BNE: if (a != b) pc = ins.target;
      default: ;
    endcase
    // x0 swallows its result
    if (res.reg_written && ins.rd != 5'd0) begin
      gpr[ins.rd] = res.wr_val;
      res.wr_idx  = ins.rd;
    end else begin
      res.reg_written = 1'b0;
      res.wr_val      = '0;
      res.wr_idx      = '0;
    end
    res.next_pc = pc;
    res.st_addr = last_st_addr;
    res.st_val  = last_st_val;
    return res;
  endfunction

  always @(posedge clk) begin
    retire_t exp_res;
    retire_t got_res;
    if (!rst_n) begin
      pc           = START_PC;
      last_st_addr = 32'hFFFF_FFFF;
      last_st_val  = '0;
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      retire_q.delete();
      mismatch_count = 0;
      retired_count  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_res = out_tdata;
        if (retire_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: pc=%h", got_res.next_pc);
        end else begin
          exp_res = retire_q.pop_front();
          if (got_res !== exp_res) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result %0d mismatch", retired_count);
              $display("  exp pc=%h wr=%b idx=%0d val=%h err=%b st=%b sa=%h sv=%h",
                       exp_res.next_pc, exp_res.reg_written, exp_res.wr_idx,
                       exp_res.wr_val, exp_res.bounds_err, exp_res.store_done,
                       exp_res.st_addr, exp_res.st_val);
              $display("  got pc=%h wr=%b idx=%0d val=%h err=%b st=%b sa=%h sv=%h",
                       got_res.next_pc, got_res.reg_written, got_res.wr_idx,
                       got_res.wr_val, got_res.bounds_err, got_res.store_done,
                       got_res.st_addr, got_res.st_val);
            end
          end
        end
        retired_count++;
      end
      if (in_tvalid && in_tready)
        retire_q.push_back(retire_instr(instr_t'(in_tdata)));
    end
    retire_pending = retire_q.size();
  end

endmodule

// File: test/tb_rv32_subset_execute_unit.sv
// ---------------------------------------------------------------------------
// tb_rv32_subset_execute_unit
// Stimulus and verdict for the execute unit. A directed program covers every
// opcode, operand extremes, x0 writes, memory edge and wraparound addresses
// and branch targets; then random instruction words follow in bursts, with
// memory accesses biased toward valid addresses. The receiver stalls on its
// own pattern, including one long hold-off. Checking is in the checker.
// ---------------------------------------------------------------------------
module tb_rv32_subset_execute_unit;
  import rv32eu_pkg::*;

  localparam logic [3:0] CMD_RSVD_LO    = 4'd12;
  localparam logic [3:0] CMD_RSVD_HI    = 4'd15;
  localparam int         RANDOM_ITEMS   = 1625;
  localparam int         LONG_STALL     = 300;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatch_count;
  int retire_pending;
  int retired_count;
  int items_sent;
  int n_alu, n_load, n_store, n_branch, n_rsvd;
  int idle_cycles;
  bit run_done;

  rv32_subset_execute_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rv32_subset_execute_unit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .retire_pending (retire_pending),
    .retired_count  (retired_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_rv32_subset_execute_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(input logic [IN_TDATA_W-1:0] w);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'({$urandom, $urandom, $urandom});
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic issue(input logic [3:0] op, input logic [4:0] rd, input logic [4:0] rs1,
                       input logic [4:0] rs2, input logic [31:0] imm,
                       input logic [31:0] tgt);
    case (op)
      CMD_LW:           n_load++;
      CMD_SW:           n_store++;
      CMD_BEQ, CMD_BNE: n_branch++;
      default:          if (op > CMD_BNE) n_rsvd++; else n_alu++;
    endcase
    push_word({5'd0, tgt, imm, rs2, rs1, rd, op});
    items_sent++;
  endtask

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      2, 3:    return 32'($urandom_range(0, 127)) - 32'd64;
      default: return $urandom & 32'h0000_0FFF;
    endcase
  endfunction

  // offsets from x0: a hot area so loads see earlier stores, plus the top edge
  function automatic logic [31:0] mem_offset();
    case ($urandom_range(0, 3))
      0, 1:    return 32'($urandom_range(0, 15) * 4 + ($urandom_range(0, 7) == 0));
      2:       return 32'($urandom_range(0, MEM_BYTES - 4));
      default: return 32'(MEM_BYTES - $urandom_range(1, 8));
    endcase
  endfunction

  task automatic issue_random();
    int unsigned pick;
    logic [3:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] imm;
    pick = $urandom_range(0, 99);
    rd   = 5'($urandom);
    rs1  = 5'($urandom);
    rs2  = 5'($urandom);
    imm  = rand_imm();
    if (pick < 40) begin
      op = 4'($urandom_range(CMD_ADDI, CMD_ORI));
    end else if (pick < 80) begin
      op = (pick < 60) ? CMD_LW : CMD_SW;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin rs1 = 5'd0; imm = mem_offset(); end
        6, 7:             imm = 32'($urandom_range(0, 255)) - 32'd128;
        default:          ;
      endcase
    end else if (pick < 95) begin
      op = $urandom_range(0, 1) ? CMD_BEQ : CMD_BNE;
      if ($urandom_range(0, 9) < 3) rs2 = rs1;
    end else begin
      op = 4'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    end
    issue(op, rd, rs1, rs2, imm, $urandom);
  endtask

  // receiver: random stall patterns, one long hold-off while the sender keeps going
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    bit          held;
    held  = 1'b0;
    phase = 0;
    wait (rst_n);
    while (!run_done) begin
      if (!held && items_sent >= 500) begin
        held = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 4);
        span = $urandom_range(10, 80);
        repeat (span) begin
          @(negedge clk);
          phase++;
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            2:       out_tready <= ($urandom_range(0, 9) != 0);
            3:       out_tready <= phase[0];
            default: out_tready <= ($urandom_range(0, 4) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int burst_left;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    run_done   = 1'b0;
    items_sent = 0;
    n_alu      = 0;
    n_load     = 0;
    n_store    = 0;
    n_branch   = 0;
    n_rsvd     = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // operand extremes and wrapping arithmetic
    issue(CMD_ADDI, 5'd1,  5'd0,  5'd0,  32'h7FFF_FFFF, 32'h0);
    issue(CMD_ADDI, 5'd2,  5'd0,  5'd0,  32'h8000_0000, 32'h0);
    issue(CMD_ADDI, 5'd31, 5'd1,  5'd0,  32'd1,         32'h0);
    issue(CMD_ADD,  5'd3,  5'd1,  5'd1,  32'h0,         32'h0);
    issue(CMD_SUB,  5'd4,  5'd2,  5'd1,  32'h0,         32'h0);
    issue(CMD_SUB,  5'd5,  5'd0,  5'd1,  32'h0,         32'h0);
    issue(CMD_AND,  5'd6,  5'd1,  5'd31, 32'h0,         32'h0);
    issue(CMD_OR,   5'd7,  5'd1,  5'd2,  32'h0,         32'h0);
    issue(CMD_XOR,  5'd8,  5'd31, 5'd31, 32'h0,         32'h0);
    issue(CMD_ANDI, 5'd9,  5'd1,  5'd0,  32'hFFFF_FFFF, 32'h0);
    issue(CMD_ORI,  5'd10, 5'd0,  5'd0,  32'hFFFF_FFFF, 32'h0);
    // writes to x0 are dropped
    issue(CMD_ADDI, 5'd0,  5'd1,  5'd0,  32'd5,         32'h0);
    issue(CMD_ADD,  5'd0,  5'd31, 5'd31, 32'h0,         32'h0);
    // memory: last valid word, one past it, wrapped addresses, unaligned
    issue(CMD_ADDI, 5'd11, 5'd0,  5'd0,  32'(MEM_BYTES - 4), 32'h0);
    issue(CMD_SW,   5'd0,  5'd11, 5'd10, 32'd0,         32'h0);
    issue(CMD_LW,   5'd12, 5'd11, 5'd0,  32'd0,         32'h0);
    issue(CMD_SW,   5'd0,  5'd11, 5'd1,  32'd1,         32'h0);
    issue(CMD_LW,   5'd13, 5'd0,  5'd0,  32'hFFFF_FFFF, 32'h0);
    issue(CMD_SW,   5'd0,  5'd0,  5'd31, 32'hFFFF_FFFC, 32'h0);
    issue(CMD_SW,   5'd0,  5'd0,  5'd1,  32'd1,         32'h0);
    issue(CMD_LW,   5'd31, 5'd11, 5'd0,  32'(-(MEM_BYTES - 4)), 32'h0);
    // branches, taken and not, to the extremes of the target range
    issue(CMD_BEQ,  5'd0,  5'd31, 5'd31, 32'h0,         32'hFFFF_FFFC);
    issue(CMD_BEQ,  5'd0,  5'd1,  5'd2,  32'h0,         32'hFFFF_FFFF);
    issue(CMD_BNE,  5'd0,  5'd1,  5'd2,  32'h0,         32'h0);
    issue(CMD_BNE,  5'd0,  5'd0,  5'd0,  32'h0,         32'hFFFF_FFFF);
    issue(CMD_RSVD_LO, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_RSVD_HI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      issue_random();
      burst_left--;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (retire_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_done = 1'b1;

    $display("covered %0d instructions: %0d alu, %0d loads, %0d stores, %0d branches,",
             items_sent, n_alu, n_load, n_store, n_branch);
    $display("%0d reserved opcodes; %0d results compared, %0d left unanswered",
             n_rsvd, retired_count, retire_pending);
    if (mismatch_count == 0 && retire_pending == 0) begin
      $display("tb_rv32_subset_execute_unit passed");
    end else begin
      $display("tb_rv32_subset_execute_unit failed");
    end
    $finish;
  end

endmodule
